>>> rtl/pal_pkg.sv
// shared constants, codes and types for the positional array list
// used by pal_cell, positional_array_list and pal_checker
package pal_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // compare width, one bit of headroom over both count and position
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;
  localparam logic [OP_W-1:0] OP_AMEND  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // where a cell loads its entry from
  localparam logic [2:0] SRC_KEEP  = 3'd0;
  localparam logic [2:0] SRC_LEFT  = 3'd1;
  localparam logic [2:0] SRC_RIGHT = 3'd2;
  localparam logic [2:0] SRC_KEY   = 3'd3;
  localparam logic [2:0] SRC_REPL  = 3'd4;

  typedef struct packed {
    logic       compare;
    logic [2:0] src;
  } cell_ctrl_t;

endpackage

>>> rtl/pal_cell.sv
// one list entry: holds a word, shifts from either neighbor, compares to the key
// depends on pal_pkg
module pal_cell import pal_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] key,
  input  logic [DATA_W-1:0] repl,
  input  logic [DATA_W-1:0] from_left,
  input  logic [DATA_W-1:0] from_right,
  output logic [DATA_W-1:0] data,
  output logic              match
);

  always_ff @(posedge clk) begin
    unique case (ctrl.src)
      SRC_KEEP:  data <= data;
      SRC_LEFT:  data <= from_left;
      SRC_RIGHT: data <= from_right;
      SRC_KEY:   data <= key;
      SRC_REPL:  data <= repl;
      default:   data <= data;
    endcase
    match <= ctrl.compare && (data == key);
  end

endmodule

>>> rtl/positional_array_list.sv
// top level of the positional array list: command register, row of entry cells,
// result register; depends on pal_pkg and pal_cell
//
// usage:
//   input channel (in_valid/in_ready) carries one word: operation, position,
//   value, new_value. output channel (out_valid/out_ready) carries one word
//   per input: status, found_position, removed_value, list_length.
//   each input passes a compare step and an update step: in the accept cycle
//   every cell compares its entry against value; in the next cycle the first
//   match is picked from the registered match bits, the cells shift or load,
//   and the result register is written. out_valid rises as the result register
//   is written and stays high until the result is taken.
//   a new word is not taken while one is in the compare-then-update pass
//   through the cell row; in_ready drops during the update cycle.
//   a new word is accepted while the previous result is being taken in the
//   same cycle. if the receiver stalls, the result holds and in_ready stays
//   low until it is taken.
//   reset (rst, synchronous) empties the list and drops out_valid; in_ready
//   is low while rst is high. entry contents are not cleared, since entries
//   at or above the length are never read.
module positional_array_list import pal_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] new_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ST_W-1:0]          status,
  output logic [POS_W-1:0]         found_position,
  output logic signed [DATA_W-1:0] removed_value,
  output logic [POS_W-1:0]         list_length
);

  logic              busy;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] nval_q;

  logic              accept;
  logic [DATA_W-1:0] key;
  cell_ctrl_t        ctrl [CAPACITY];
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] hit;

  logic [CMP_W-1:0]  pos_e;
  logic [CMP_W-1:0]  cnt_e;
  logic [CMP_W-1:0]  pos_m1;
  logic [CMP_W-1:0]  found_e;
  logic [IDX_W-1:0]  first;
  logic              any_hit;
  logic              ins_bad;
  logic              ins_full;
  logic              del_bad;
  logic              do_insert;
  logic              do_delete;
  logic              do_amend;
  logic [ST_W-1:0]   status_next;

  assign in_ready = !rst && !busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign key      = busy ? val_q : $unsigned(value);

  assign pos_e  = CMP_W'(pos_q);
  assign cnt_e  = CMP_W'(count);
  assign pos_m1 = pos_e - CMP_W'(1);

  assign ins_bad  = (pos_q == '0) || (pos_e > cnt_e + CMP_W'(1));
  assign ins_full = (cnt_e == CMP_W'(CAPACITY));
  assign del_bad  = (pos_q == '0) || (pos_e > cnt_e);

  // first match below the length
  always_comb begin
    first   = '0;
    any_hit = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        first   = IDX_W'(i);
        any_hit = 1'b1;
      end
    end
  end

  assign found_e = CMP_W'(first) + CMP_W'(1);

  always_comb begin
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    do_amend    = 1'b0;
    status_next = ST_OK;
    unique case (op_q)
      OP_INSERT: begin
        if (ins_bad) status_next = ST_BAD_POS;
        else if (ins_full) status_next = ST_FULL;
        else do_insert = 1'b1;
      end
      OP_DELETE: begin
        if (del_bad) status_next = ST_BAD_POS;
        else do_delete = 1'b1;
      end
      OP_LOCATE: begin
        if (!any_hit) status_next = ST_NOT_FOUND;
      end
      OP_AMEND: begin
        if (!any_hit) status_next = ST_NOT_FOUND;
        else do_amend = 1'b1;
      end
      default: status_next = ST_OK;
    endcase
  end

  always_comb begin
    count_next = count;
    if (busy && do_insert) count_next = count + CNT_W'(1);
    else if (busy && do_delete) count_next = count - CNT_W'(1);
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] left_in;
      logic [DATA_W-1:0] right_in;

      if (g == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_mid_l
        assign left_in = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_in = '0;
      end else begin : g_mid_r
        assign right_in = cell_data[g+1];
      end

      assign hit[g] = match[g] && (CMP_W'(g) < cnt_e);

      always_comb begin
        ctrl[g].compare = accept;
        ctrl[g].src     = SRC_KEEP;
        if (busy) begin
          priority if (do_insert && CMP_W'(g) == pos_m1) ctrl[g].src = SRC_KEY;
          else if (do_insert && CMP_W'(g) > pos_m1) ctrl[g].src = SRC_LEFT;
          else if (do_delete && CMP_W'(g) >= pos_m1 && g != CAPACITY - 1)
            ctrl[g].src = SRC_RIGHT;
          else if (do_amend && IDX_W'(g) == first) ctrl[g].src = SRC_REPL;
          else ctrl[g].src = SRC_KEEP;
        end
      end

      pal_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[g]),
        .key        (key),
        .repl       (nval_q),
        .from_left  (left_in),
        .from_right (right_in),
        .data       (cell_data[g]),
        .match      (match[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      count <= count_next;
      if (accept) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
      end
      if (busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      pos_q  <= position;
      val_q  <= $unsigned(value);
      nval_q <= $unsigned(new_value);
    end
    if (busy) begin
      status         <= status_next;
      found_position <= (any_hit && (op_q == OP_LOCATE || op_q == OP_AMEND)) ?
                        found_e[POS_W-1:0] : '0;
      removed_value  <= do_delete ? $signed(cell_data[pos_m1[IDX_W-1:0]]) : '0;
      list_length    <= POS_W'(count_next);
    end
  end

endmodule

>>> rtl/pal_checker.sv
// port-level checks for positional_array_list, attached by bind
// depends on pal_pkg
module pal_checker import pal_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ST_W-1:0]          status,
  input logic [POS_W-1:0]         found_position,
  input logic signed [DATA_W-1:0] removed_value,
  input logic [POS_W-1:0]         list_length
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(list_length) && $stable(removed_value))
    else $error("result word changed while stalled");

  // one word in flight: no accept right after an accept
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted during update");

  // every accepted word yields a result once its update step is done
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing after accept");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOT_FOUND |-> found_position == '0)
    else $error("not found result carries a position");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> CMP_W'(list_length) <= CMP_W'(CAPACITY))
    else $error("length above capacity");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

>>> sim/tb_positional_array_list.sv
// testbench for positional_array_list: directed and random insert, delete, locate and
// amend words against a mirrored copy of the list, with random idling on both channels
// depends on pal_pkg and the positional_array_list rtl
module tb_positional_array_list;
  import pal_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_WORDS   = 850;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic [POS_W-1:0]         found_position;
    logic signed [DATA_W-1:0] removed_value;
    logic [POS_W-1:0]         list_length;
  } list_reply_t;

  // mirrored list contents and the replies owed by the block, oldest first
  class list_mirror;
    logic signed [DATA_W-1:0] entries [CAPACITY];
    int                       count;
    list_reply_t              owed_replies [$];
    int                       fails;

    function new();
      count = 0;
      fails = 0;
    endfunction

    function void apply_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] val,
                                logic signed [DATA_W-1:0] nval);
      list_reply_t r;
      int          k;
      int          hit;
      r.status         = ST_OK;
      r.found_position = '0;
      r.removed_value  = '0;
      hit = -1;
      case (op)
        OP_INSERT: begin
          // position check wins over the full check
          if (pos == 0 || int'(pos) > count + 1) begin
            r.status = ST_BAD_POS;
          end else if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (k = count; k > int'(pos) - 1; k--) entries[k] = entries[k-1];
            entries[pos-1] = val;
            count++;
          end
        end
        OP_DELETE: begin
          if (pos == 0 || int'(pos) > count) begin
            r.status = ST_BAD_POS;
          end else begin
            r.removed_value = entries[pos-1];
            for (k = pos; k < count; k++) entries[k-1] = entries[k];
            count--;
          end
        end
        default: begin
          for (k = count - 1; k >= 0; k--) if (entries[k] == val) hit = k;
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.found_position = POS_W'(hit + 1);
            if (op == OP_AMEND) entries[hit] = nval;
          end
        end
      endcase
      r.list_length = POS_W'(count);
      owed_replies.push_back(r);
    endfunction

    function void check_reply(list_reply_t got);
      list_reply_t want;
      if (owed_replies.size() == 0) begin
        $error("result word with no command outstanding");
        fails++;
        return;
      end
      want = owed_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, got %0d", want.found_position,
               got.found_position);
        fails++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected %0d, got %0d", want.removed_value,
               got.removed_value);
        fails++;
      end
      if (got.list_length !== want.list_length) begin
        $error("list_length: expected %0d, got %0d", want.list_length, got.list_length);
        fails++;
      end
    endfunction

    function int outstanding();
      return owed_replies.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          operation = OP_LOCATE;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic signed [DATA_W-1:0] new_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ST_W-1:0]          status;
  logic [POS_W-1:0]         found_position;
  logic signed [DATA_W-1:0] removed_value;
  logic [POS_W-1:0]         list_length;

  list_mirror mirror = new();
  bit         feed_quiet = 1'b0;
  bit         drain_quiet = 1'b1;
  int         idle_cycles = 0;

  positional_array_list dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .position       (position),
    .value          (value),
    .new_value      (new_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_position (found_position),
    .removed_value  (removed_value),
    .list_length    (list_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stretches of back-to-back traffic alternate with random gaps
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 19));
  endfunction

  // small pool makes duplicates and locate hits common
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      4, 5: return DATA_W'($urandom_range(1, 6));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val,
                           logic signed [DATA_W-1:0] nval);
    int gap;
    gap = draw_gap(feed_quiet);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    new_value <= nval;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    mirror.apply_command(op, pos, val, nval);
  endtask

  task automatic send_random_word(bit growing);
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       r;
    r = $urandom_range(0, 99);
    if (growing) op = (r < 55) ? OP_INSERT : (r < 70) ? OP_DELETE :
                      (r < 85) ? OP_LOCATE : OP_AMEND;
    else         op = (r < 20) ? OP_INSERT : (r < 60) ? OP_DELETE :
                      (r < 80) ? OP_LOCATE : OP_AMEND;
    if ($urandom_range(0, 99) < 15 || op == OP_LOCATE || op == OP_AMEND)
      pos = POS_W'($urandom_range(0, 31));
    else if (op == OP_INSERT)
      pos = POS_W'($urandom_range(1, mirror.count + 1));
    else
      pos = POS_W'($urandom_range(1, (mirror.count > 0) ? mirror.count : 1));
    if (op != OP_INSERT && mirror.count > 0 && $urandom_range(0, 99) < 60)
      val = mirror.entries[$urandom_range(0, mirror.count - 1)];
    else
      val = pick_value();
    send_word(op, pos, val, pick_value());
  endtask

  // result side: random stalls, check every word taken
  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap(drain_quiet);
      @(negedge clk);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      mirror.check_reply({status, found_position, removed_value, list_length});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int                       i;
    logic signed [DATA_W-1:0] fill;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // empty list: nothing to find, nothing to delete, bad insert positions
    send_word(OP_LOCATE, 5'd0, 32'sd0, 32'sd0);
    send_word(OP_AMEND, 5'd1, 32'sd7, 32'sd9);
    send_word(OP_DELETE, 5'd1, 32'sd0, 32'sd0);
    send_word(OP_INSERT, 5'd0, 32'sd3, 32'sd0);
    send_word(OP_INSERT, 5'd2, 32'sd3, 32'sd0);

    // fill to capacity, alternating front and tail inserts, with duplicates
    for (i = 0; i < CAPACITY; i++) begin
      fill = (i == 0) ? 32'sh8000_0000 : (i == 1) ? 32'sh7fff_ffff :
             (i % 3 == 0) ? -32'sd1 : DATA_W'(i);
      send_word(OP_INSERT, (i % 2 == 1) ? 5'd1 : POS_W'(i + 1), fill, 32'sd0);
    end

    send_word(OP_INSERT, 5'd18, 32'sd1, 32'sd0);
    send_word(OP_INSERT, 5'd16, 32'sd1, 32'sd0);
    send_word(OP_AMEND, 5'd31, -32'sd1, 32'sh5555_aaaa);
    send_word(OP_LOCATE, 5'd0, -32'sd1, 32'sd0);
    send_word(OP_DELETE, 5'd16, 32'sd0, 32'sd0);
    send_word(OP_DELETE, 5'd1, 32'sd0, 32'sd0);
    send_word(OP_DELETE, 5'd31, 32'sd0, 32'sd0);

    // alternate growing and shrinking phases so the list swings empty to full
    for (i = 0; i < RANDOM_WORDS; i++) send_random_word(((i / 60) % 2) == 0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
